[sv/wcdf_pkg.sv]
// shared types, constants and codes for the window coverage deletion finder
package wcdf_pkg;

  localparam int DEPTH_BITS    = 16;
  localparam int FRACTION_BITS = 8;
  localparam int SUM_BITS      = 32;
  localparam int COUNT_BITS    = 16;
  localparam int MEAN_BITS     = 24;
  localparam int POS_BITS      = 32;
  localparam int WLEN_BITS     = 16;
  localparam int DIVIDEND_BITS = SUM_BITS + FRACTION_BITS;
  localparam int HIGH_BITS     = DIVIDEND_BITS - MEAN_BITS;
  localparam int STEP_BITS     = $clog2(MEAN_BITS);

  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_MIN_DELETION  = 1'b1;

  localparam logic KIND_WINDOW   = 1'b0;
  localparam logic KIND_DELETION = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_S,
    ST_WAIT_S,
    ST_START_R,
    ST_WAIT_R,
    ST_EMIT_WIN,
    ST_EMIT_DEL
  } wcdf_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[sv/window_coverage_deletion_finder.sv]
// top level: window accumulation, mean sequencing, deletion run tracking and output word
// Takes one position word per cycle while a window is filling (in_ready stays high in idle).
// A position that closes a window (count reaches window_length, or last_position is set)
// starts the mean sequence: the single shared divider computes the subject mean and then the
// reference mean, 24 quotient bits one per cycle each, so in_ready stays low from the closing
// word until the window word, and any deletion word that follows, is loaded for output. A division
// by a zero count or one whose mean saturates skips the quotient bit steps. The sequence
// also waits on out_ready. The block puts out the window summary word and, when a run of at
// least min_deletion_length ends, a deletion word. The user must write both registers over
// the APB port (byte addresses 0 and 4) only while idle; the block does not enforce this.
module window_coverage_deletion_finder
  import wcdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DEPTH_BITS-1:0] subject_depth,
  input  logic [DEPTH_BITS-1:0] reference_depth,
  input  logic                  last_position,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  record_kind,
  output logic [POS_BITS-1:0]   start_position,
  output logic [MEAN_BITS-1:0]  subject_mean,
  output logic [MEAN_BITS-1:0]  reference_mean,
  output logic [POS_BITS-1:0]   run_length,
  output logic                  final_record
);

  wcdf_state_t state, state_next;

  logic [WLEN_BITS-1:0]  window_length;
  logic [POS_BITS-1:0]   min_deletion_length;

  logic [SUM_BITS-1:0]   subject_sum, reference_sum;
  logic [COUNT_BITS-1:0] subject_nz, reference_nz;
  logic [WLEN_BITS-1:0]  positions_in_window;
  logic [POS_BITS-1:0]   window_start;
  logic                  run_open;
  logic [POS_BITS-1:0]   run_start;
  logic [POS_BITS-1:0]   run_total;
  logic                  last_seen;
  logic                  del_pending;
  logic [MEAN_BITS-1:0]  sm_hold, rm_hold;

  logic [SUM_BITS:0]     subject_sum_wide, reference_sum_wide;
  logic [SUM_BITS-1:0]   subject_sum_next, reference_sum_next;
  logic [COUNT_BITS-1:0] subject_nz_next, reference_nz_next;
  logic [WLEN_BITS-1:0]  positions_next;
  logic [WLEN_BITS-1:0]  wl_eff;
  logic                  closes;

  logic                  is_del;
  logic [POS_BITS-1:0]   run_start_next;
  logic [POS_BITS:0]     run_total_wide;
  logic [POS_BITS-1:0]   run_total_next;
  logic                  report_del;

  logic                  accept;
  logic                  out_free;
  logic                  cfg_write;
  logic                  div_start;
  logic [SUM_BITS-1:0]   div_sum;
  logic [COUNT_BITS-1:0] div_count;
  logic [MEAN_BITS-1:0]  div_quotient;
  div_status_t           div_status;
  logic                  load_win, load_del;

  wcdf_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .sum      (div_sum),
    .count    (div_count),
    .quotient (div_quotient),
    .status   (div_status)
  );

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_WINDOW_LENGTH: prdata = DATA_BITS'(window_length);
      REG_MIN_DELETION:  prdata = min_deletion_length;
      default:           prdata = '0;
    endcase
  end

  // accumulation of the incoming position
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign subject_sum_wide   = {1'b0, subject_sum} + (SUM_BITS+1)'(subject_depth);
  assign reference_sum_wide = {1'b0, reference_sum} + (SUM_BITS+1)'(reference_depth);
  assign subject_sum_next   = subject_sum_wide[SUM_BITS] ? '1 : subject_sum_wide[SUM_BITS-1:0];
  assign reference_sum_next =
    reference_sum_wide[SUM_BITS] ? '1 : reference_sum_wide[SUM_BITS-1:0];
  assign subject_nz_next   = (subject_depth != '0 && subject_nz != '1) ?
                             subject_nz + 1'b1 : subject_nz;
  assign reference_nz_next = (reference_depth != '0 && reference_nz != '1) ?
                             reference_nz + 1'b1 : reference_nz;
  assign positions_next = (positions_in_window != '1) ?
                          positions_in_window + 1'b1 : positions_in_window;
  assign wl_eff = (window_length == '0) ? WLEN_BITS'(1) : window_length;
  assign closes = (positions_next >= wl_eff) || last_position;

  // run tracking for the window being closed
  assign is_del         = (sm_hold == '0) && (rm_hold != '0);
  assign run_start_next = run_open ? run_start : window_start;
  assign run_total_wide = {1'b0, (run_open ? run_total : '0)} + (POS_BITS+1)'(positions_in_window);
  assign run_total_next = run_total_wide[POS_BITS] ? '1 : run_total_wide[POS_BITS-1:0];
  // a run is reported when it ends (a failing window, or the last position) if long enough
  assign report_del = is_del ? (last_seen && run_total_next >= min_deletion_length)
                             : (run_open && run_total >= min_deletion_length);

  assign div_sum   = (state == ST_START_S) ? subject_sum : reference_sum;
  assign div_count = (state == ST_START_S) ? subject_nz : reference_nz;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (accept && closes) state_next = ST_START_S;
      ST_START_S:  state_next = ST_WAIT_S;
      ST_WAIT_S:   if (div_status.done) state_next = ST_START_R;
      ST_START_R:  state_next = ST_WAIT_R;
      ST_WAIT_R:   if (div_status.done) state_next = ST_EMIT_WIN;
      ST_EMIT_WIN: if (out_free) state_next = report_del ? ST_EMIT_DEL : ST_IDLE;
      ST_EMIT_DEL: if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    load_win  = 1'b0;
    load_del  = 1'b0;
    case (state)
      ST_IDLE:     in_ready  = 1'b1;
      ST_START_S:  div_start = 1'b1;
      ST_START_R:  div_start = 1'b1;
      ST_EMIT_WIN: load_win  = out_free;
      ST_EMIT_DEL: load_del  = out_free;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      window_length       <= WLEN_BITS'(1);
      min_deletion_length <= '0;
      subject_sum         <= '0;
      reference_sum       <= '0;
      subject_nz          <= '0;
      reference_nz        <= '0;
      positions_in_window <= '0;
      window_start        <= '0;
      run_open            <= 1'b0;
      run_start           <= '0;
      run_total           <= '0;
      last_seen           <= 1'b0;
      del_pending         <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (paddr[2])
          REG_WINDOW_LENGTH: window_length <= pwdata[WLEN_BITS-1:0];
          REG_MIN_DELETION:  min_deletion_length <= pwdata;
          default:           ;
        endcase
      end

      if (accept) begin
        subject_sum         <= subject_sum_next;
        reference_sum       <= reference_sum_next;
        subject_nz          <= subject_nz_next;
        reference_nz        <= reference_nz_next;
        positions_in_window <= positions_next;
        last_seen           <= last_position;
      end

      if (state == ST_WAIT_S && div_status.done) sm_hold <= div_quotient;
      if (state == ST_WAIT_R && div_status.done) rm_hold <= div_quotient;

      if (load_win || load_del) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (load_win) begin
        record_kind    <= KIND_WINDOW;
        start_position <= window_start;
        subject_mean   <= sm_hold;
        reference_mean <= rm_hold;
        run_length     <= '0;
        final_record   <= last_seen && !report_del;
        del_pending    <= report_del;
        if (is_del) begin
          run_start <= run_start_next;
          run_total <= run_total_next;
        end
        run_open            <= is_del && !last_seen;
        window_start        <= last_seen ? '0 : window_start + POS_BITS'(positions_in_window);
        subject_sum         <= '0;
        reference_sum       <= '0;
        subject_nz          <= '0;
        reference_nz        <= '0;
        positions_in_window <= '0;
      end

      if (load_del) begin
        record_kind    <= KIND_DELETION;
        start_position <= run_start;
        subject_mean   <= '0;
        reference_mean <= '0;
        run_length     <= run_total;
        final_record   <= last_seen;
        del_pending    <= 1'b0;
      end
    end
  end

  a_del_zero_means: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind == KIND_DELETION |-> subject_mean == '0 && reference_mean == '0)
    else $error("deletion word carries a nonzero mean");

  a_win_zero_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind == KIND_WINDOW |-> run_length == '0)
    else $error("window word carries a run length");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> state == ST_WAIT_S || state == ST_WAIT_R)
    else $error("divider finished outside a wait state");

  a_del_follows_win: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT_DEL |-> del_pending)
    else $error("deletion emit without a pending run");

endmodule

[sv/wcdf_divider.sv]
// shared restoring divider: (sum << fraction bits) / count, saturated, one bit per cycle
module wcdf_divider
  import wcdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SUM_BITS-1:0]   sum,
  input  logic [COUNT_BITS-1:0] count,
  output logic [MEAN_BITS-1:0]  quotient,
  output div_status_t           status
);

  logic [DIVIDEND_BITS-1:0] dividend;
  logic [HIGH_BITS-1:0]     high_part;
  logic                     saturate;

  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] divisor;
  logic [MEAN_BITS-1:0]  shreg;
  logic [STEP_BITS-1:0]  steps;
  logic                  busy;
  logic                  done;

  logic [COUNT_BITS:0]   trial;
  logic                  fits;
  logic [COUNT_BITS:0]   trial_diff;

  assign dividend  = DIVIDEND_BITS'(sum) << FRACTION_BITS;
  assign high_part = dividend[DIVIDEND_BITS-1:MEAN_BITS];
  // quotient reaches 2^24 exactly when the upper dividend bits reach the divisor
  assign saturate  = 32'(high_part) >= 32'(count);

  assign trial      = {rem, shreg[MEAN_BITS-1]};
  assign fits       = trial >= {1'b0, divisor};
  assign trial_diff = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (count == '0) begin
          shreg <= '0;
          done  <= 1'b1;
        end else if (saturate) begin
          shreg <= '1;
          done  <= 1'b1;
        end else begin
          rem     <= COUNT_BITS'(high_part);
          shreg   <= dividend[MEAN_BITS-1:0];
          divisor <= count;
          steps   <= '0;
          busy    <= 1'b1;
        end
      end else if (busy) begin
        rem   <= fits ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        shreg <= {shreg[MEAN_BITS-2:0], fits};
        steps <= steps + 1'b1;
        if (steps == STEP_BITS'(MEAN_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = shreg;
  assign status.busy = busy;
  assign status.done = done;

endmodule

[tb/sv/window_coverage_deletion_finder_test.sv]
// self-checking testbench for the window coverage deletion finder
module window_coverage_deletion_finder_test
  import wcdf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RESET_CYCLES  = 9;

  typedef struct {
    logic [DEPTH_BITS-1:0] subject;
    logic [DEPTH_BITS-1:0] reference;
    logic                  last;
  } position_t;

  typedef struct {
    logic                 kind;
    logic [POS_BITS-1:0]  start;
    logic [MEAN_BITS-1:0] subject_mean;
    logic [MEAN_BITS-1:0] reference_mean;
    logic [POS_BITS-1:0]  length;
    logic                 final_flag;
  } record_t;

  typedef enum int {
    WIN_DELETED,
    WIN_COVERED,
    WIN_EMPTY,
    WIN_SUBJECT_ONLY
  } window_shape_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_BITS-1:0]  paddr = '0;
  logic [DATA_BITS-1:0]  pwdata = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [DEPTH_BITS-1:0] subject_depth = '0;
  logic [DEPTH_BITS-1:0] reference_depth = '0;
  logic                  last_position = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  record_kind;
  logic [POS_BITS-1:0]   start_position;
  logic [MEAN_BITS-1:0]  subject_mean;
  logic [MEAN_BITS-1:0]  reference_mean;
  logic [POS_BITS-1:0]   run_length;
  logic                  final_record;

  window_coverage_deletion_finder dut (.*);

  always #5 clk = ~clk;

  // register copies
  logic [WLEN_BITS-1:0] window_length_cfg = 16'd1;
  logic [POS_BITS-1:0]  min_deletion_cfg = '0;

  // window and run state of the predictor
  logic [SUM_BITS-1:0]   subject_total = '0;
  logic [SUM_BITS-1:0]   reference_total = '0;
  logic [COUNT_BITS-1:0] subject_hits = '0;
  logic [COUNT_BITS-1:0] reference_hits = '0;
  logic [WLEN_BITS-1:0]  window_fill = '0;
  logic [POS_BITS-1:0]   window_origin = '0;
  logic                  deletion_open = 1'b0;
  logic [POS_BITS-1:0]   deletion_origin = '0;
  logic [POS_BITS-1:0]   deletion_span = '0;

  position_t pending_positions[$];
  record_t   expected_records[$];
  position_t word_on_bus;

  int sender_idle_pct = 25;
  int receiver_idle_pct = 56;
  int mismatch_count = 0;
  int words_accepted = 0;
  int windows_checked = 0;
  int deletions_checked = 0;
  int settings_used = 1;
  int cycle_count = 0;

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [MEAN_BITS-1:0] nonzero_mean(logic [SUM_BITS-1:0] total,
                                                        logic [COUNT_BITS-1:0] hits);
    logic [DIVIDEND_BITS-1:0] q;
    if (hits == 0) return '0;
    q = {total, {FRACTION_BITS{1'b0}}} / hits;
    return (q > {{HIGH_BITS{1'b0}}, {MEAN_BITS{1'b1}}}) ? '1 : q[MEAN_BITS-1:0];
  endfunction

  // accumulates one accepted position and queues the records it closes
  function automatic void track_position(position_t p);
    logic [WLEN_BITS-1:0] wl;
    logic [MEAN_BITS-1:0] sm, rm;
    record_t recs[3];
    int n;
    n = 0;
    wl = (window_length_cfg == 0) ? 16'd1 : window_length_cfg;
    subject_total = sat_add32(subject_total, {16'd0, p.subject});
    reference_total = sat_add32(reference_total, {16'd0, p.reference});
    if (p.subject != 0 && subject_hits != 16'hFFFF) subject_hits++;
    if (p.reference != 0 && reference_hits != 16'hFFFF) reference_hits++;
    if (window_fill != 16'hFFFF) window_fill++;
    if (window_fill < wl && !p.last) return;

    sm = nonzero_mean(subject_total, subject_hits);
    rm = nonzero_mean(reference_total, reference_hits);
    recs[n++] = '{kind: KIND_WINDOW, start: window_origin, subject_mean: sm,
                  reference_mean: rm, length: '0, final_flag: 1'b0};
    if (sm == 0 && rm != 0) begin
      if (!deletion_open) begin
        deletion_open = 1'b1;
        deletion_origin = window_origin;
        deletion_span = '0;
      end
      deletion_span = sat_add32(deletion_span, {16'd0, window_fill});
    end else if (deletion_open) begin
      if (deletion_span >= min_deletion_cfg)
        recs[n++] = '{kind: KIND_DELETION, start: deletion_origin, subject_mean: '0,
                      reference_mean: '0, length: deletion_span, final_flag: 1'b0};
      deletion_open = 1'b0;
    end
    // a run still open at the final position is closed here
    if (p.last && deletion_open) begin
      if (deletion_span >= min_deletion_cfg)
        recs[n++] = '{kind: KIND_DELETION, start: deletion_origin, subject_mean: '0,
                      reference_mean: '0, length: deletion_span, final_flag: 1'b0};
      deletion_open = 1'b0;
    end
    window_origin = window_origin + {16'd0, window_fill};
    subject_total = '0;
    reference_total = '0;
    subject_hits = '0;
    reference_hits = '0;
    window_fill = '0;
    if (p.last) begin
      window_origin = '0;
      recs[n-1].final_flag = 1'b1;
    end
    for (int i = 0; i < n; i++) expected_records.push_back(recs[i]);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("mismatch after %0d checked words: %s got 0x%0h expected 0x%0h",
             windows_checked + deletions_checked, what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_position(word_on_bus);
        words_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_positions.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          word_on_bus = pending_positions.pop_front();
          in_valid <= 1'b1;
          subject_depth <= word_on_bus.subject;
          reference_depth <= word_on_bus.reference;
          last_position <= word_on_bus.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    record_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_records.size() == 0) begin
          report_mismatch("word with nothing expected, start_position", start_position, '0);
        end else begin
          want = expected_records.pop_front();
          if (record_kind !== want.kind)
            report_mismatch("record_kind", record_kind, want.kind);
          if (start_position !== want.start)
            report_mismatch("start_position", start_position, want.start);
          if (subject_mean !== want.subject_mean)
            report_mismatch("subject_mean", subject_mean, want.subject_mean);
          if (reference_mean !== want.reference_mean)
            report_mismatch("reference_mean", reference_mean, want.reference_mean);
          if (run_length !== want.length)
            report_mismatch("run_length", run_length, want.length);
          if (final_record !== want.final_flag)
            report_mismatch("final_record", final_record, want.final_flag);
          if (want.kind == KIND_WINDOW) windows_checked++;
          else deletions_checked++;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_register(logic reg_index, logic [DATA_BITS-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_index == REG_WINDOW_LENGTH) window_length_cfg = value[WLEN_BITS-1:0];
    else min_deletion_cfg = value;
  endtask

  task automatic set_registers(logic [WLEN_BITS-1:0] wl, logic [POS_BITS-1:0] min_len);
    write_register(REG_WINDOW_LENGTH, {16'd0, wl});
    write_register(REG_MIN_DELETION, min_len);
    settings_used++;
  endtask

  // sampled at the falling edge so the driver's updates have settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_positions.size() != 0 || in_valid || expected_records.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_position(logic [15:0] sd, logic [15:0] rd, logic last);
    pending_positions.push_back('{subject: sd, reference: rd, last: last});
  endtask

  function automatic logic [DEPTH_BITS-1:0] random_depth();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return DEPTH_BITS'($urandom_range(1, 15));
      3: return DEPTH_BITS'(1) << $urandom_range(0, DEPTH_BITS - 1);
      default: return DEPTH_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  // whole windows of a chosen shape, the final one possibly short
  task automatic add_sequence(int windows, ref int added);
    int wl, len;
    window_shape_t shape;
    logic [15:0] sd, rd;
    wl = (window_length_cfg == 0) ? 1 : window_length_cfg;
    for (int w = 0; w < windows; w++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: shape = WIN_DELETED;
        4, 5, 6:    shape = WIN_COVERED;
        7:          shape = WIN_EMPTY;
        default:    shape = WIN_SUBJECT_ONLY;
      endcase
      len = (w == windows - 1 && $urandom_range(0, 1) == 1) ? $urandom_range(1, wl) : wl;
      for (int i = 0; i < len; i++) begin
        case (shape)
          WIN_DELETED: begin
            sd = '0;
            rd = ($urandom_range(0, 3) == 0) ? random_depth() : 16'($urandom_range(1, 65535));
          end
          WIN_COVERED: begin
            sd = random_depth();
            rd = random_depth();
          end
          WIN_EMPTY: begin
            sd = '0;
            rd = '0;
          end
          default: begin
            sd = random_depth();
            rd = '0;
          end
        endcase
        push_position(sd, rd, (w == windows - 1) && (i == len - 1));
        added++;
      end
    end
  endtask

  task automatic add_noise(int count, ref int added);
    for (int i = 0; i < count; i++) begin
      push_position(random_depth(), random_depth(), $urandom_range(0, 7) == 0);
      added++;
    end
  endtask

  task automatic fill_random(int budget);
    int added;
    added = 0;
    while (added < budget) begin
      if ($urandom_range(0, 4) == 0) add_noise($urandom_range(1, 4), added);
      else add_sequence($urandom_range(1, 4), added);
    end
  endtask

  task automatic random_phase(logic [WLEN_BITS-1:0] wl, logic [POS_BITS-1:0] min_len);
    wait_drained();
    set_registers(wl, min_len);
    fill_random(12);
    // hold back until every pending word has come out
    wait_drained();
    fill_random(12);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset settings: every position is a window, every run reported
    push_position(16'h0000, 16'h0000, 1'b0);
    push_position(16'hFFFF, 16'hFFFF, 1'b0);
    push_position(16'h0000, 16'hFFFF, 1'b0);
    push_position(16'h0000, 16'h0001, 1'b0);
    push_position(16'h0001, 16'h0000, 1'b0);
    push_position(16'h0000, 16'h0005, 1'b1);
    push_position(16'h5555, 16'hAAAA, 1'b0);
    push_position(16'hAAAA, 16'h5555, 1'b1);
    wait_drained();

    // full window, then a short final window still in a deletion
    set_registers(16'd3, 32'd0);
    push_position(16'h0007, 16'h0000, 1'b0);
    push_position(16'h0000, 16'h0009, 1'b0);
    push_position(16'h0003, 16'h0003, 1'b0);
    push_position(16'h0000, 16'h0004, 1'b0);
    push_position(16'h0000, 16'h0000, 1'b1);
    wait_drained();

    // zero length acts as one; one run long enough, one too short
    set_registers(16'd0, 32'd2);
    push_position(16'h0000, 16'h0009, 1'b0);
    push_position(16'h0000, 16'h0009, 1'b0);
    push_position(16'h0004, 16'h0004, 1'b0);
    push_position(16'h0000, 16'h0009, 1'b0);
    push_position(16'h0004, 16'h0004, 1'b1);
    wait_drained();

    // window shortened while partly filled
    set_registers(16'd5, 32'd2);
    push_position(16'h0000, 16'h0010, 1'b0);
    push_position(16'h0000, 16'h0020, 1'b0);
    push_position(16'h0000, 16'h0000, 1'b0);
    wait_drained();
    set_registers(16'd2, 32'd2);
    push_position(16'h0000, 16'h0030, 1'b0);
    push_position(16'h0100, 16'h0000, 1'b0);
    push_position(16'h0000, 16'h0040, 1'b1);
    wait_drained();

    // widest window closed early by the final position; run never long enough
    set_registers(16'hFFFF, 32'hFFFF_FFFF);
    push_position(16'h0000, 16'h0064, 1'b0);
    push_position(16'h0000, 16'h0000, 1'b0);
    push_position(16'h0000, 16'h00C8, 1'b1);

    random_phase(16'd2, 32'd0);
    random_phase(16'd4, 32'd6);

    sender_idle_pct = 56;
    receiver_idle_pct = 25;
    random_phase(16'd3, 32'hFFFF_FFFF);
    random_phase(16'd1, 32'd3);

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    random_phase(16'd7, 32'd0);
    random_phase(16'($urandom_range(1, 6)), 32'($urandom_range(0, 20)));

    wait_drained();
    $display("covered %0d position words under %0d register settings", words_accepted,
             settings_used);
    $display("checked %0d window summaries and %0d deletion records", windows_checked,
             deletions_checked);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
